// ===== hw/rtl/spd_pkg.sv =====
// Package for the serial packet deframer: widths, register indexes, status codes
// and the controller state type.
// It depends on nothing else; the deframer top level takes its names by scope.
package spd_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int PHASE_W         = 7;
    localparam int LEN_W           = 6;
    localparam int TYPE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int OUT_TDATA_W     = 24;
    localparam int OUT_TUSER_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'b1;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h21;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h52;

    // Phase values for idle and header, and the first phase of the storing range.
    localparam logic [PHASE_W-1:0] PH_IDLE   = 7'd0;
    localparam logic [PHASE_W-1:0] PH_HEADER = 7'd1;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 7'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GOOD     = 2'd0,
        STAT_BAD_END  = 2'd1,
        STAT_BAD_SUM  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_RX,
        ST_RD,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/serial_packet_deframer.sv =====
// A bad or empty packet's status item is registered and appears in the cycle after its tail
// byte is taken. A good packet's payload items are read back one at a time: a store read in
// ST_RD, then a load of the output register in ST_OUT once the output slot is free.
// Throughput: one received byte per cycle, held off during read-back and at a tail byte until
// the output slot is free. Reset clears the controller, counters and output valid; the payload
// store is not cleared, as only entries written in the current packet are read.
module serial_packet_deframer #(
    parameter int STORE_DEPTH = spd_pkg::STORE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spd_pkg::BYTE_W-1:0]          cfg_data,
    // Received bytes. s_tdata: rx_byte[7:0].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spd_pkg::BYTE_W-1:0]          s_tdata,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: packet_type[1:0], payload_length[7:2], byte_index[13:8],
    // data_byte[21:14], zero [23:22].
    output logic [spd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tuser: status[1:0], has_data[2].
    output logic [spd_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Payload store: payload bytes and the checksum byte after them. The checksum and the
    // payload's running sum are also in registers, so the tail decision needs no store read.
    logic [spd_pkg::BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [spd_pkg::BYTE_W-1:0] mem_wd;
    logic                       mem_re;
    logic [AW-1:0]              mem_ra;
    logic [spd_pkg::BYTE_W-1:0] rd_data_reg;

    // Configuration registers.
    logic [spd_pkg::BYTE_W-1:0] start_byte_reg;
    logic [spd_pkg::BYTE_W-1:0] end_byte_reg;

    // Packet state.
    spd_pkg::state_t            state_reg, state_next;
    logic [spd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [spd_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [spd_pkg::TYPE_W-1:0] type_reg, type_next;
    logic [spd_pkg::BYTE_W-1:0] sum_reg, sum_next;
    logic [spd_pkg::BYTE_W-1:0] csum_reg, csum_next;
    logic [spd_pkg::LEN_W-1:0]  k_reg, k_next;

    // Output register.
    logic                        m_valid_reg, m_valid_next;
    logic [spd_pkg::STATUS_W-1:0] o_status_reg, o_status_next;
    logic [spd_pkg::TYPE_W-1:0]  o_type_reg, o_type_next;
    logic [spd_pkg::LEN_W-1:0]   o_len_reg, o_len_next;
    logic                        o_has_reg, o_has_next;
    logic [spd_pkg::LEN_W-1:0]   o_idx_reg, o_idx_next;
    logic [spd_pkg::BYTE_W-1:0]  o_data_reg, o_data_next;
    logic                        o_last_reg, o_last_next;

    logic                        out_free;
    logic [spd_pkg::PHASE_W-1:0] tail_pos;
    logic [spd_pkg::PHASE_W-1:0] store_idx;
    logic                        at_tail;
    logic                        in_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= spd_pkg::START_BYTE_RST;
            end_byte_reg   <= spd_pkg::END_BYTE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spd_pkg::REG_START_BYTE: start_byte_reg <= cfg_data;
                spd_pkg::REG_END_BYTE:   end_byte_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // The output slot can take a new item if it is empty or being emptied now.
    assign out_free  = !m_valid_reg || m_tready;
    assign tail_pos  = spd_pkg::PHASE_W'(len_reg) + spd_pkg::PHASE_W'(3);
    assign store_idx = phase_reg - spd_pkg::PH_FIRST;
    assign at_tail   = (phase_reg != spd_pkg::PH_IDLE) && (phase_reg != spd_pkg::PH_HEADER)
                       && (phase_reg >= tail_pos);
    // Input is held off during read-back, which also keeps store writes and reads apart,
    // and at the tail byte until the output slot is free.
    assign s_tready  = (state_reg == spd_pkg::ST_RX) && (!at_tail || out_free);
    assign in_fire   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        sum_next      = sum_reg;
        csum_next     = csum_reg;
        k_next        = k_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_status_next = o_status_reg;
        o_type_next   = o_type_reg;
        o_len_next    = o_len_reg;
        o_has_next    = o_has_reg;
        o_idx_next    = o_idx_reg;
        o_data_next   = o_data_reg;
        o_last_next   = o_last_reg;
        mem_we        = 1'b0;
        mem_wa        = AW'(store_idx);
        mem_wd        = s_tdata;
        mem_re        = 1'b0;
        mem_ra        = AW'(k_reg);

        case (state_reg)
            spd_pkg::ST_RX:
            begin
                if (in_fire)
                begin
                    if (phase_reg == spd_pkg::PH_IDLE)
                    begin
                        if (s_tdata == start_byte_reg)
                        begin
                            phase_next = spd_pkg::PH_HEADER;
                        end
                    end
                    else if (phase_reg == spd_pkg::PH_HEADER)
                    begin
                        len_next   = s_tdata[spd_pkg::LEN_W-1:0];
                        type_next  = s_tdata[spd_pkg::BYTE_W-1 -: spd_pkg::TYPE_W];
                        sum_next   = '0;
                        phase_next = spd_pkg::PH_FIRST;
                    end
                    else if (!at_tail)
                    begin
                        mem_we = 1'b1;
                        // Payload bytes feed the running sum; the byte after them is
                        // the checksum.
                        if (store_idx == spd_pkg::PHASE_W'(len_reg))
                        begin
                            csum_next = s_tdata;
                        end
                        else
                        begin
                            sum_next = sum_reg + s_tdata;
                        end
                        phase_next = phase_reg + spd_pkg::PHASE_W'(1);
                    end
                    else
                    begin
                        phase_next    = spd_pkg::PH_IDLE;
                        o_type_next   = type_reg;
                        o_len_next    = len_reg;
                        o_has_next    = 1'b0;
                        o_idx_next    = '0;
                        o_data_next   = '0;
                        o_last_next   = 1'b1;
                        if (s_tdata != end_byte_reg)
                        begin
                            o_status_next = spd_pkg::STAT_BAD_END;
                            m_valid_next  = 1'b1;
                        end
                        else if (~sum_reg != csum_reg)
                        begin
                            o_status_next = spd_pkg::STAT_BAD_SUM;
                            m_valid_next  = 1'b1;
                        end
                        else if (len_reg == '0)
                        begin
                            o_status_next = spd_pkg::STAT_GOOD;
                            m_valid_next  = 1'b1;
                        end
                        else
                        begin
                            k_next     = '0;
                            state_next = spd_pkg::ST_RD;
                        end
                        if (state_next == spd_pkg::ST_RX)
                        begin
                            len_next  = '0;
                            type_next = '0;
                        end
                    end
                end
            end

            spd_pkg::ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = spd_pkg::ST_OUT;
            end

            spd_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    o_status_next = spd_pkg::STAT_GOOD;
                    o_type_next   = type_reg;
                    o_len_next    = len_reg;
                    o_has_next    = 1'b1;
                    o_idx_next    = k_reg;
                    o_data_next   = rd_data_reg;
                    o_last_next   = (k_reg == len_reg - spd_pkg::LEN_W'(1));
                    if (k_reg == len_reg - spd_pkg::LEN_W'(1))
                    begin
                        len_next   = '0;
                        type_next  = '0;
                        state_next = spd_pkg::ST_RX;
                    end
                    else
                    begin
                        k_next     = k_reg + spd_pkg::LEN_W'(1);
                        state_next = spd_pkg::ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = spd_pkg::ST_RX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= spd_pkg::ST_RX;
            phase_reg   <= spd_pkg::PH_IDLE;
            len_reg     <= '0;
            type_reg    <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        csum_reg     <= csum_next;
        o_status_reg <= o_status_next;
        o_type_reg   <= o_type_next;
        o_len_reg    <= o_len_next;
        o_has_reg    <= o_has_next;
        o_idx_reg    <= o_idx_next;
        o_data_reg   <= o_data_next;
        o_last_reg   <= o_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_ra];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, o_data_reg, o_idx_reg, o_len_reg, o_type_reg};
    assign m_tuser  = {o_has_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

endmodule
